/* hw/rtl/sdf_pkg.sv */
// Shared types and constants for the signed decimal text formatter.
// Used by sdf_bcd_cell, sdf_digit_chain and signed_decimal_text_formatter.
package sdf_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_DIGITS = 19;   // |most negative 64-bit value| has 19 digits
    localparam int BCD_W      = 4;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_WIDTH = 2'd0,
        REG_MIN_DIGITS  = 2'd1,
        REG_LEFT_ALIGN  = 2'd2,
        REG_FORCE_PLUS  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     ser_bit;
    } chain_ctl_t;

endpackage

/* hw/rtl/signed_decimal_text_formatter.sv */
// Signed 64-bit integer to printf %d text, one character per output beat.
// A new value is taken only while idle, after the last character of the previous one.
// Conversion is a 64-step double-dabble pass through the digit chain, then one
// character per cycle goes out while m_tready does not stall the output.
// Reset (rst_n, async, active low) clears state, output valid and config registers.
module signed_decimal_text_formatter #(
    parameter int MAX_TEXT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdf_pkg::VALUE_W-1:0]   s_tdata,   // [63:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdf_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] char_code
    output logic                          m_tlast,   // last_char
    input  logic                          cfg_wr_en,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CW  = ($clog2(MAX_TEXT + 1) > 7) ? $clog2(MAX_TEXT + 1) : 7;
    localparam int NDW = $clog2(sdf_pkg::NUM_DIGITS + 1);
    localparam int BCW = $clog2(sdf_pkg::VALUE_W);
    localparam logic [CW-1:0]  MAX_T    = CW'(MAX_TEXT);
    localparam logic [NDW-1:0] ND_FULL  = NDW'(sdf_pkg::NUM_DIGITS);
    localparam logic [BCW-1:0] LAST_BIT = BCW'(sdf_pkg::VALUE_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_LAY,
        ST_LAY2,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [6:0] field_width_reg;
    logic [5:0] min_digits_reg;
    logic       left_align_reg;
    logic       force_plus_reg;

    logic [sdf_pkg::VALUE_W-1:0] mag_reg;
    logic                        neg_reg;
    logic [BCW-1:0]              bit_cnt_reg;
    logic [NDW-1:0]              ndig_reg;
    logic [CW-1:0]               zeros_reg;
    logic [CW-1:0]               body_reg;
    logic [CW-1:0]               wid_reg;
    logic [CW-1:0]               a_reg;
    logic [CW-1:0]               b_reg;
    logic [CW-1:0]               c_reg;
    logic [CW-1:0]               d_reg;
    logic [CW-1:0]               last_reg;
    logic [CW-1:0]               pos_reg;

    logic                        m_tvalid_reg;
    logic [sdf_pkg::CHAR_W-1:0]  m_tdata_reg;
    logic                        m_tlast_reg;

    logic                        accept;
    logic                        emit_go;
    logic                        at_last;
    logic                        norm_shift;
    logic                        in_digits;
    logic                        sign_len;
    logic [sdf_pkg::BCD_W-1:0]   top_digit;
    logic [sdf_pkg::CHAR_W-1:0]  char_next;
    sdf_pkg::chain_ctl_t         chain_ctl;

    logic [CW-1:0] md_ext, nd_ext, ndt_max, lim, ndt, fw_ext, wid;
    logic [CW-1:0] total, pad, a_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit_go  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign at_last  = (pos_reg == last_reg);
    assign sign_len = neg_reg | force_plus_reg;

    assign norm_shift = (state_reg == ST_NORM) && (top_digit == '0) && (ndig_reg != NDW'(1));
    assign in_digits  = (pos_reg >= c_reg) && (pos_reg < d_reg);

    always_comb
    begin
        priority if (pos_reg < a_reg)
            char_next = sdf_pkg::CH_SPACE;
        else if (pos_reg < b_reg)
            char_next = neg_reg ? sdf_pkg::CH_MINUS : sdf_pkg::CH_PLUS;
        else if (pos_reg < c_reg)
            char_next = sdf_pkg::CH_ZERO;
        else if (pos_reg < d_reg)
            char_next = sdf_pkg::CH_ZERO + sdf_pkg::CHAR_W'(top_digit);
        else
            char_next = sdf_pkg::CH_SPACE;
    end

    always_comb
    begin
        chain_ctl.ser_bit = mag_reg[sdf_pkg::VALUE_W-1];
        priority if (accept)
            chain_ctl.op = sdf_pkg::CELL_CLEAR;
        else if (state_reg == ST_CONV)
            chain_ctl.op = sdf_pkg::CELL_DABBLE;
        else if (norm_shift || (emit_go && in_digits))
            chain_ctl.op = sdf_pkg::CELL_SHIFT;
        else
            chain_ctl.op = sdf_pkg::CELL_HOLD;
    end

    sdf_digit_chain u_chain (
        .clk       (clk),
        .ctl       (chain_ctl),
        .top_digit (top_digit)
    );

    // layout of the text: [pad][sign][zeros][digits][pad]
    always_comb
    begin
        md_ext  = CW'(min_digits_reg);
        nd_ext  = CW'(ndig_reg);
        ndt_max = (md_ext > nd_ext) ? md_ext : nd_ext;
        lim     = MAX_T - CW'(sign_len);
        ndt     = (ndt_max > lim) ? lim : ndt_max;
        fw_ext  = CW'(field_width_reg);
        wid     = (fw_ext > MAX_T) ? MAX_T : fw_ext;
        total   = (wid_reg > body_reg) ? wid_reg : body_reg;
        pad     = total - body_reg;
        a_val   = left_align_reg ? '0 : pad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= '0;
            min_digits_reg  <= '0;
            left_align_reg  <= 1'b0;
            force_plus_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (sdf_pkg::cfg_reg_t'(cfg_index))
                sdf_pkg::REG_FIELD_WIDTH: field_width_reg <= cfg_data;
                sdf_pkg::REG_MIN_DIGITS:  min_digits_reg  <= cfg_data[5:0];
                sdf_pkg::REG_LEFT_ALIGN:  left_align_reg  <= cfg_data[0];
                sdf_pkg::REG_FORCE_PLUS:  force_plus_reg  <= cfg_data[0];
                default:                  field_width_reg <= field_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: if (accept) state_reg <= ST_CONV;
                ST_CONV: if (bit_cnt_reg == LAST_BIT) state_reg <= ST_NORM;
                ST_NORM: if (!norm_shift) state_reg <= ST_LAY;
                ST_LAY:  state_reg <= ST_LAY2;
                ST_LAY2: state_reg <= ST_EMIT;
                ST_EMIT: if (emit_go && at_last) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase

            if (emit_go)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= char_next;
                m_tlast_reg  <= at_last;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg     <= s_tdata[sdf_pkg::VALUE_W-1] ? ('0 - s_tdata) : s_tdata;
            neg_reg     <= s_tdata[sdf_pkg::VALUE_W-1];
            bit_cnt_reg <= '0;
            ndig_reg    <= ND_FULL;
        end
        if (state_reg == ST_CONV)
        begin
            mag_reg     <= {mag_reg[sdf_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BCW'(1);
        end
        if (norm_shift)
            ndig_reg <= ndig_reg - NDW'(1);
        if (state_reg == ST_LAY)
        begin
            zeros_reg <= ndt - nd_ext;
            body_reg  <= ndt + CW'(sign_len);
            wid_reg   <= wid;
        end
        if (state_reg == ST_LAY2)
        begin
            a_reg    <= a_val;
            b_reg    <= a_val + CW'(sign_len);
            c_reg    <= a_val + CW'(sign_len) + zeros_reg;
            d_reg    <= a_val + body_reg;
            last_reg <= total - CW'(1);
            pos_reg  <= '0;
        end
        if (emit_go)
            pos_reg <= pos_reg + CW'(1);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while a conversion was already running");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && at_last) |=> s_tready)
        else $error("block not idle after the last beat of a number");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= last_reg))
        else $error("character position ran past the end of the text");

    a_layout_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
            (a_reg <= b_reg && b_reg <= c_reg && c_reg < d_reg && d_reg <= last_reg + CW'(1)))
        else $error("text layout boundaries out of order");

    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ndig_reg != '0 && ndig_reg <= ND_FULL))
        else $error("digit count out of range");
`endif

endmodule

/* hw/rtl/sdf_bcd_cell.sv */
// One BCD digit cell: double-dabble step, digit shift toward the top, clear, hold.
// Depends on sdf_pkg.
module sdf_bcd_cell (
    input  logic                      clk,
    input  sdf_pkg::cell_op_t         op,
    input  logic                      bit_in,
    input  logic [sdf_pkg::BCD_W-1:0] digit_in,
    output logic [sdf_pkg::BCD_W-1:0] digit,
    output logic                      carry_out
);

    logic [sdf_pkg::BCD_W-1:0] digit_reg;
    logic [sdf_pkg::BCD_W-1:0] digit_next;
    logic [sdf_pkg::BCD_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        unique case (op)
            sdf_pkg::CELL_HOLD:   digit_next = digit_reg;
            sdf_pkg::CELL_CLEAR:  digit_next = '0;
            sdf_pkg::CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            sdf_pkg::CELL_SHIFT:  digit_next = digit_in;
            default:              digit_next = digit_reg;
        endcase
    end

    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

/* hw/rtl/sdf_digit_chain.sv */
// Row of BCD cells: binary bits enter at the bottom, digits leave at the top.
// Depends on sdf_pkg and sdf_bcd_cell.
module sdf_digit_chain (
    input  logic                      clk,
    input  sdf_pkg::chain_ctl_t       ctl,
    output logic [sdf_pkg::BCD_W-1:0] top_digit
);

    logic [sdf_pkg::BCD_W-1:0] dig [sdf_pkg::NUM_DIGITS+1];
    logic                      carry [sdf_pkg::NUM_DIGITS];

    assign dig[0]   = '0;
    assign carry[0] = ctl.ser_bit;

    for (genvar i = 0; i < sdf_pkg::NUM_DIGITS; i++)
    begin : g_cell
        if (i < sdf_pkg::NUM_DIGITS - 1)
        begin : g_mid
            sdf_bcd_cell u_cell (
                .clk       (clk),
                .op        (ctl.op),
                .bit_in    (carry[i]),
                .digit_in  (dig[i]),
                .digit     (dig[i+1]),
                .carry_out (carry[i+1])
            );
        end
        else
        begin : g_top
            sdf_bcd_cell u_cell (
                .clk       (clk),
                .op        (ctl.op),
                .bit_in    (carry[i]),
                .digit_in  (dig[i]),
                .digit     (dig[i+1]),
                .carry_out ()
            );
        end
    end

    assign top_digit = dig[sdf_pkg::NUM_DIGITS];

endmodule
